// ----- hw/rtl/tsnrt_pkg.sv -----
package tsnrt_pkg;

  // Input item modes.
  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_OPEN  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_HDR   = 2'd1;
  localparam logic [1:0] KIND_GAP   = 2'd2;
  localparam logic [1:0] KIND_DUP   = 2'd3;

  // Chunk status codes.
  localparam logic [1:0] STAT_IN_ORDER = 2'd0;
  localparam logic [1:0] STAT_STORED   = 2'd1;
  localparam logic [1:0] STAT_DUP      = 2'd2;
  localparam logic [1:0] STAT_BEYOND   = 2'd3;

  // Configuration register indexes.
  localparam int         CFG_IDX_W  = 1;
  localparam logic [0:0] CFG_WINDOW = 1'b0;
  localparam logic [0:0] CFG_DELAY  = 1'b1;

  localparam logic [31:0] WINDOW_RESET = 32'd65536;
  localparam logic [3:0]  DELAY_RESET  = 4'd2;
  localparam logic [3:0]  QUIET_MAX    = 4'd15;
  localparam logic [31:0] HALF_SERIAL  = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DECIDE,
    ST_GCOUNT,
    ST_HDR,
    ST_GEMIT,
    ST_DRD,
    ST_DEMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic drain;
    logic load_chunk;
    logic count_step;
    logic load_hdr;
    logic gap_adv;
    logic load_gap;
    logic dup_rd;
    logic load_dup;
    logic finish_build;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bit0;
    logic       count_done;
    logic       gaps_zero;
    logic       gap_end;
    logic       gap_final;
    logic       dups_zero;
    logic       dup_final;
  } sts_t;

endpackage

// ----- hw/rtl/tsnrt_ctrl.sv -----
module tsnrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tsnrt_pkg::sts_t sts,
  output tsnrt_pkg::cmd_t cmd
);
  import tsnrt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   emit;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.mode)
          MODE_DATA:  state_nxt = ST_DECIDE;
          MODE_BUILD: state_nxt = ST_GCOUNT;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_DECIDE: begin
        if (sts.bit0) begin
          cmd.drain = 1'b1;
        end else if (out_free) begin
          cmd.load_chunk = 1'b1;
          emit           = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_GCOUNT: begin
        cmd.count_step = 1'b1;
        if (sts.count_done) begin
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          cmd.load_hdr = 1'b1;
          emit         = 1'b1;
          if (!sts.gaps_zero) begin
            state_nxt = ST_GEMIT;
          end else if (!sts.dups_zero) begin
            state_nxt = ST_DRD;
          end else begin
            cmd.finish_build = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end
      end
      ST_GEMIT: begin
        if (!sts.gap_end) begin
          cmd.gap_adv = 1'b1;
        end else if (out_free) begin
          cmd.gap_adv  = 1'b1;
          cmd.load_gap = 1'b1;
          emit         = 1'b1;
          if (sts.gap_final) begin
            if (!sts.dups_zero) begin
              state_nxt = ST_DRD;
            end else begin
              cmd.finish_build = 1'b1;
              state_nxt        = ST_IDLE;
            end
          end
        end
      end
      ST_DRD: begin
        cmd.dup_rd = 1'b1;
        state_nxt  = ST_DEMIT;
      end
      ST_DEMIT: begin
        if (out_free) begin
          cmd.load_dup = 1'b1;
          emit         = 1'b1;
          if (sts.dup_final) begin
            cmd.finish_build = 1'b1;
            state_nxt        = ST_IDLE;
          end else begin
            state_nxt = ST_DRD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

endmodule

// ----- hw/rtl/tsnrt_datapath.sv -----
module tsnrt_datapath #(
  parameter int WINDOW    = 64,
  parameter int DUP_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tsnrt_pkg::cmd_t                cmd,
  output tsnrt_pkg::sts_t                sts,
  input  logic                           cfg_we,
  input  logic [tsnrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic [1:0]                     in_mode,
  input  logic [31:0]                    in_tsn,
  input  logic                           in_immediate_flag,
  input  logic                           in_first_of_packet,
  input  logic                           in_last_of_packet,
  input  logic                           in_ack_now,
  output logic [1:0]                     out_kind,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_tsn_value,
  output logic [6:0]                     out_delivered_count,
  output logic [6:0]                     out_gap_start,
  output logic [6:0]                     out_gap_end,
  output logic [5:0]                     out_gap_total,
  output logic [4:0]                     out_dup_total,
  output logic [31:0]                    out_window_out,
  output logic                           out_sack_now,
  output logic                           out_start_delay_timer,
  output logic                           out_last
);
  import tsnrt_pkg::*;

  localparam int IW  = $clog2(WINDOW);
  localparam int PW  = $clog2(WINDOW + 1);
  localparam int GW  = $clog2(WINDOW / 2 + 1);
  localparam int CW  = $clog2(DUP_DEPTH + 1);
  localparam int DIW = (DUP_DEPTH > 1) ? $clog2(DUP_DEPTH) : 1;

  // Configuration registers.
  logic [31:0] win_r;
  logic [3:0]  ppds_r;

  // Latched input item.
  logic [1:0]  item_mode_r;
  logic [31:0] item_tsn_r;
  logic        item_imm_r, item_first_r, item_last_r, item_now_r;

  // Receive state.
  logic [31:0]     cum_r, cum_nxt;
  logic [WINDOW-1:0] bm_r, bm_nxt;
  logic [CW-1:0]   dup_cnt_r, dup_cnt_nxt;
  logic [3:0]      quiet_r, quiet_nxt;
  logic            force_r, force_nxt;
  logic            hole_r, hole_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [PW-1:0]   deliv_r, deliv_nxt;

  // SACK walk state.
  logic [WINDOW-1:0] scan_r, scan_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   start_r, start_nxt;
  logic            prev_r, prev_nxt;
  logic            inblk_r, inblk_nxt;
  logic [GW-1:0]   gcnt_r, gcnt_nxt;
  logic [GW-1:0]   gidx_r, gidx_nxt;
  logic [CW-1:0]   dup_idx_r, dup_idx_nxt;

  logic [31:0] dup_mem [DUP_DEPTH];
  logic [31:0] dup_rd_r;

  // Chunk classification on the latched TSN.
  logic [31:0] off, offm1;
  logic [IW-1:0] bm_idx;
  logic in_order, in_win, beyond, stored_hit, dup_hit, dup_room, mem_we;
  logic is_data;

  // Packet-end decision.
  logic       send_v, sn_v, sd_v;
  logic [3:0] q_v;
  logic       force_v;

  assign off        = item_tsn_r - cum_r;
  assign offm1      = off - 32'd1;
  assign bm_idx     = offm1[IW-1:0];
  assign in_order   = (off == 32'd1);
  assign in_win     = (off >= 32'd2) && (off <= 32'(WINDOW));
  assign beyond     = (off > 32'(WINDOW)) && (off <= HALF_SERIAL);
  assign stored_hit = bm_r[bm_idx];
  assign dup_hit    = (in_win && stored_hit) || (!in_order && !in_win && !beyond);
  assign dup_room   = (dup_cnt_r < CW'(DUP_DEPTH));
  assign is_data    = (item_mode_r == MODE_DATA);
  assign mem_we     = cmd.exec && is_data && dup_hit && dup_room;

  assign sts.mode       = item_mode_r;
  assign sts.bit0       = bm_r[0];
  assign sts.count_done = (pos_r == PW'(WINDOW - 1));
  assign sts.gaps_zero  = (gcnt_r == '0);
  assign sts.gap_end    = scan_r[0] && !scan_r[1];
  assign sts.gap_final  = ((gidx_r + GW'(1)) == gcnt_r);
  assign sts.dups_zero  = (dup_cnt_r == '0);
  assign sts.dup_final  = ((dup_idx_r + CW'(1)) == dup_cnt_r);

  always_comb begin
    send_v = force_r || hole_r || (|bm_r);
    q_v    = quiet_r;
    sd_v   = 1'b0;
    if (!send_v) begin
      if (quiet_r < QUIET_MAX) begin
        q_v = quiet_r + 4'd1;
      end
      send_v = (q_v >= ppds_r);
      sd_v   = !send_v;
    end
    sn_v = send_v;
    if (!item_last_r) begin
      sn_v = 1'b0;
      sd_v = 1'b0;
    end
  end

  always_comb begin
    cum_nxt     = cum_r;
    bm_nxt      = bm_r;
    dup_cnt_nxt = dup_cnt_r;
    quiet_nxt   = quiet_r;
    force_nxt   = force_r;
    hole_nxt    = hole_r;
    stat_nxt    = stat_r;
    deliv_nxt   = deliv_r;
    scan_nxt    = scan_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    prev_nxt    = prev_r;
    inblk_nxt   = inblk_r;
    gcnt_nxt    = gcnt_r;
    gidx_nxt    = gidx_r;
    dup_idx_nxt = dup_idx_r;
    force_v     = force_r;

    if (cmd.exec) begin
      case (item_mode_r)
        MODE_DATA: begin
          if (item_first_r) begin
            hole_nxt = |bm_r;
            force_v  = 1'b0;
          end
          force_v   = force_v || item_now_r || item_imm_r;
          deliv_nxt = '0;
          if (in_order) begin
            cum_nxt   = item_tsn_r;
            bm_nxt    = bm_r >> 1;
            deliv_nxt = PW'(1);
            stat_nxt  = STAT_IN_ORDER;
          end else if (in_win && !stored_hit) begin
            bm_nxt[bm_idx] = 1'b1;
            stat_nxt       = STAT_STORED;
          end else if (beyond) begin
            force_v  = 1'b1;
            stat_nxt = STAT_BEYOND;
          end else begin
            force_v  = 1'b1;
            stat_nxt = STAT_DUP;
          end
          if (mem_we) begin
            dup_cnt_nxt = dup_cnt_r + CW'(1);
          end
          force_nxt = force_v;
        end
        MODE_BUILD: begin
          scan_nxt = bm_r >> 1;
          pos_nxt  = PW'(1);
          gcnt_nxt = '0;
          prev_nxt = bm_r[0];
        end
        MODE_OPEN: begin
          cum_nxt     = item_tsn_r - 32'd1;
          bm_nxt      = '0;
          dup_cnt_nxt = '0;
          quiet_nxt   = '0;
          force_nxt   = 1'b0;
          hole_nxt    = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd.drain) begin
      cum_nxt   = cum_r + 32'd1;
      bm_nxt    = bm_r >> 1;
      deliv_nxt = deliv_r + PW'(1);
    end

    if (cmd.load_chunk && item_last_r) begin
      quiet_nxt = q_v;
      force_nxt = 1'b0;
      hole_nxt  = 1'b0;
    end

    if (cmd.count_step) begin
      if (scan_r[0] && !prev_r) begin
        gcnt_nxt = gcnt_r + GW'(1);
      end
      prev_nxt = scan_r[0];
      scan_nxt = scan_r >> 1;
      pos_nxt  = pos_r + PW'(1);
    end

    if (cmd.load_hdr) begin
      scan_nxt    = bm_r >> 1;
      pos_nxt     = PW'(1);
      gidx_nxt    = '0;
      inblk_nxt   = 1'b0;
      dup_idx_nxt = '0;
    end

    if (cmd.gap_adv) begin
      if (scan_r[0] && !inblk_r) begin
        start_nxt = pos_r;
      end
      inblk_nxt = scan_r[0] && scan_r[1];
      scan_nxt  = scan_r >> 1;
      pos_nxt   = pos_r + PW'(1);
    end

    if (cmd.load_gap) begin
      gidx_nxt = gidx_r + GW'(1);
    end

    if (cmd.load_dup) begin
      dup_idx_nxt = dup_idx_r + CW'(1);
    end

    if (cmd.finish_build) begin
      dup_cnt_nxt = '0;
      quiet_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WINDOW_RESET;
      ppds_r    <= DELAY_RESET;
      cum_r     <= '0;
      bm_r      <= '0;
      dup_cnt_r <= '0;
      quiet_r   <= '0;
      force_r   <= 1'b0;
      hole_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WINDOW) begin
        win_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_DELAY) begin
        ppds_r <= cfg_wdata[3:0];
      end
      cum_r     <= cum_nxt;
      bm_r      <= bm_nxt;
      dup_cnt_r <= dup_cnt_nxt;
      quiet_r   <= quiet_nxt;
      force_r   <= force_nxt;
      hole_r    <= hole_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode_r  <= in_mode;
      item_tsn_r   <= in_tsn;
      item_imm_r   <= in_immediate_flag;
      item_first_r <= in_first_of_packet;
      item_last_r  <= in_last_of_packet;
      item_now_r   <= in_ack_now;
    end
    stat_r    <= stat_nxt;
    deliv_r   <= deliv_nxt;
    scan_r    <= scan_nxt;
    pos_r     <= pos_nxt;
    start_r   <= start_nxt;
    prev_r    <= prev_nxt;
    inblk_r   <= inblk_nxt;
    gcnt_r    <= gcnt_nxt;
    gidx_r    <= gidx_nxt;
    dup_idx_r <= dup_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dup_mem[dup_cnt_r[DIW-1:0]] <= item_tsn_r;
    end
    if (cmd.dup_rd) begin
      dup_rd_r <= dup_mem[dup_idx_r[DIW-1:0]];
    end
  end

  // Output register; every field is rewritten on each load.
  always_ff @(posedge clk) begin
    if (cmd.load_chunk) begin
      out_kind              <= KIND_CHUNK;
      out_status            <= stat_r;
      out_tsn_value         <= cum_r;
      out_delivered_count   <= 7'(deliv_r);
      out_gap_start         <= '0;
      out_gap_end           <= '0;
      out_gap_total         <= '0;
      out_dup_total         <= '0;
      out_window_out        <= '0;
      out_sack_now          <= sn_v;
      out_start_delay_timer <= sd_v;
      out_last              <= 1'b1;
    end else if (cmd.load_hdr) begin
      out_kind              <= KIND_HDR;
      out_status            <= STAT_IN_ORDER;
      out_tsn_value         <= cum_r;
      out_delivered_count   <= '0;
      out_gap_start         <= '0;
      out_gap_end           <= '0;
      out_gap_total         <= 6'(gcnt_r);
      out_dup_total         <= 5'(dup_cnt_r);
      out_window_out        <= win_r;
      out_sack_now          <= 1'b0;
      out_start_delay_timer <= 1'b0;
      out_last              <= sts.gaps_zero && sts.dups_zero;
    end else if (cmd.load_gap) begin
      out_kind              <= KIND_GAP;
      out_status            <= STAT_IN_ORDER;
      out_tsn_value         <= cum_r;
      out_delivered_count   <= '0;
      out_gap_start         <= 7'((inblk_r ? start_r : pos_r) + PW'(1));
      out_gap_end           <= 7'(pos_r + PW'(1));
      out_gap_total         <= 6'(gcnt_r);
      out_dup_total         <= 5'(dup_cnt_r);
      out_window_out        <= '0;
      out_sack_now          <= 1'b0;
      out_start_delay_timer <= 1'b0;
      out_last              <= sts.gap_final && sts.dups_zero;
    end else if (cmd.load_dup) begin
      out_kind              <= KIND_DUP;
      out_status            <= STAT_IN_ORDER;
      out_tsn_value         <= dup_rd_r;
      out_delivered_count   <= '0;
      out_gap_start         <= '0;
      out_gap_end           <= '0;
      out_gap_total         <= 6'(gcnt_r);
      out_dup_total         <= 5'(dup_cnt_r);
      out_window_out        <= '0;
      out_sack_now          <= 1'b0;
      out_start_delay_timer <= 1'b0;
      out_last              <= sts.dup_final;
    end
  end

endmodule

// ----- hw/rtl/tsn_receive_tracker_sack_builder_unit.sv -----
// Channel   Handshake            Payload
// input     in_valid / in_stall  mode, tsn, immediate_flag, first/last_of_packet, ack_now
// result    out_valid/out_stall  kind, status, tsn_value, counts, gap offsets, window, flags
// config    cfg_we               cfg_index, cfg_wdata (no wait, no read-back)
//
// A data chunk is executed, then drains each stored TSN that an in-order
// arrival has made contiguous, then loads its status; an open or an unused
// mode is executed only. A build counts gap blocks by walking the bitmap,
// then loads a header, walks the bitmap again while emitting gap blocks, and
// for each duplicate reads the memory, then loads the result. The bitmap
// walk is the dominant cost. Reset is synchronous and active low and needs
// no clearing pass. A stalled result holds in the output register while the
// block goes on with the next item; the block waits only when it has a new
// result and the register still holds an untaken one.
module tsn_receive_tracker_sack_builder_unit #(
  parameter int WINDOW    = 64,
  parameter int DUP_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tsnrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [31:0]                     in_tsn,
  input  logic                            in_immediate_flag,
  input  logic                            in_first_of_packet,
  input  logic                            in_last_of_packet,
  input  logic                            in_ack_now,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [1:0]                      out_status,
  output logic [31:0]                     out_tsn_value,
  output logic [6:0]                      out_delivered_count,
  output logic [6:0]                      out_gap_start,
  output logic [6:0]                      out_gap_end,
  output logic [5:0]                      out_gap_total,
  output logic [4:0]                      out_dup_total,
  output logic [31:0]                     out_window_out,
  output logic                            out_sack_now,
  output logic                            out_start_delay_timer,
  output logic                            out_last
);
  import tsnrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item; it owns the handshakes.
  tsnrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the cumulative TSN, the out-of-order bitmap, the
  // duplicate memory, the packet flags and the output register.
  tsnrt_datapath #(
    .WINDOW    (WINDOW),
    .DUP_DEPTH (DUP_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_mode               (in_mode),
    .in_tsn                (in_tsn),
    .in_immediate_flag     (in_immediate_flag),
    .in_first_of_packet    (in_first_of_packet),
    .in_last_of_packet     (in_last_of_packet),
    .in_ack_now            (in_ack_now),
    .out_kind              (out_kind),
    .out_status            (out_status),
    .out_tsn_value         (out_tsn_value),
    .out_delivered_count   (out_delivered_count),
    .out_gap_start         (out_gap_start),
    .out_gap_end           (out_gap_end),
    .out_gap_total         (out_gap_total),
    .out_dup_total         (out_dup_total),
    .out_window_out        (out_window_out),
    .out_sack_now          (out_sack_now),
    .out_start_delay_timer (out_start_delay_timer),
    .out_last              (out_last)
  );

  // One item at a time: an accepted transfer closes the input channel.
  a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was in progress");

  // A chunk status result is always the only result of its item.
  a_chunk_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CHUNK) |-> out_last)
    else $error("chunk status without last");

  // The packet-end decision is either an immediate SACK or the timer.
  a_decision : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_sack_now && out_start_delay_timer))
    else $error("both immediate SACK and delay timer requested");

endmodule
